// File: design/rrsf_pkg.sv
// Shared constants and types for the round-robin / shortest-first scheduler.
package rrsf_pkg;

	// Default table size
	localparam int MAX_PROCESSES_DEF = 64;

	// Fixed field widths
	localparam int BURST_W    = 16;
	localparam int SLICE_W    = 16;
	localparam int PID_W      = 6;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE  = 1'd1;

	// Register reset values
	localparam logic [SLICE_W-1:0] SLICE_RESET = 16'h0002;

	// Policy codes
	localparam logic POLICY_RR = 1'b0;
	localparam logic POLICY_SF = 1'b1;

	// Input item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Control into the shortest-first scan unit
	typedef struct packed {
		logic clr;   // start of a new scan
		logic vld;   // a sample is present this cycle
		logic live;  // the sampled slot holds a live process
		logic skip;  // the sampled slot is the last run process
	} scan_ctl_t;

	// Scan status back to the sequencer
	typedef struct packed {
		logic best_vld;  // a live process other than the last run one was seen
		logic any_vld;   // some live process was seen
	} scan_res_t;

endpackage

// File: design/round_robin_or_shortest_first_scheduler.sv
// Load: input transfer, done state, result. Round-robin tick: pop at the head (read of the
// FIFO RAM, then of the time RAM), repeated for each dead FIFO entry dropped, then run, done.
// Shortest-first tick: scan, drain, pick and done states, one time RAM read per slot in the scan.
// One item at a time; the next input is taken while a result waits at the output register.
// Reset clears control state, counters and the live mask; the RAMs are not cleared.
module round_robin_or_shortest_first_scheduler #(
	parameter int MAX_PROCESSES = rrsf_pkg::MAX_PROCESSES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rrsf_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] burst_time
	input  logic                                s_tuser,   // [0] kind
	// Result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rrsf_pkg::OUT_DATA_W-1:0]     m_tdata,   // [5:0] process_id, [6] finished,
	                                                       // [7] load_rejected
	output logic                                m_tuser,   // [0] ran_slice
	// Configuration write port
	input  logic                                cfg_we,
	input  logic [rrsf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rrsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ID_W  = $clog2(MAX_PROCESSES);
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam int BW    = rrsf_pkg::BURST_W;

	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PROCESSES);
	localparam logic [CNT_W:0]   MAX_WIDE = (CNT_W+1)'(MAX_PROCESSES);
	localparam logic [ID_W-1:0]  LAST_ID  = ID_W'(MAX_PROCESSES - 1);

	// Sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_RR_RD    = 3'd1;
	localparam logic [2:0] S_RUN      = 3'd2;
	localparam logic [2:0] S_SF_SCAN  = 3'd3;
	localparam logic [2:0] S_SF_DRAIN = 3'd4;
	localparam logic [2:0] S_SF_PICK  = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0]                     state_q;
	logic                           policy_q;
	logic [rrsf_pkg::SLICE_W-1:0]   slice_q;
	logic [MAX_PROCESSES-1:0]       live_q;
	logic [ID_W-1:0]                head_q;
	logic [CNT_W-1:0]               fifo_cnt_q;
	logic [CNT_W-1:0]               loaded_q;
	logic [ID_W-1:0]                last_id_q;
	logic                           last_vld_q;
	logic [ID_W-1:0]                run_id_q;
	logic [ID_W-1:0]                scan_idx_q;
	logic                           smp_vld_s1;
	logic [ID_W-1:0]                smp_idx_s1;

	logic                           res_ran_q;
	logic [ID_W-1:0]                res_id_q;
	logic                           res_fin_q;
	logic                           res_rej_q;
	logic                           m_tvalid_q;
	logic                           m_tuser_q;
	logic [rrsf_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic                           in_acc;
	logic                           is_load;
	logic                           full;
	logic                           do_load;
	logic [CNT_W:0]                 tail_sum;
	logic [CNT_W:0]                 tail_wrap;
	logic [ID_W-1:0]                tail_id;
	logic [ID_W-1:0]                head_inc;
	logic [ID_W-1:0]                cand;
	logic                           cand_live;
	logic                           pick_vld;
	logic [ID_W-1:0]                pick_id;
	logic [BW-1:0]                  pick_rem;
	logic [ID_W-1:0]                run_id;
	logic [BW-1:0]                  run_rem;
	logic [BW-1:0]                  new_rem;
	logic                           run_fin;
	logic                           do_run;
	logic                           out_free;

	logic                           rem_we;
	logic [ID_W-1:0]                rem_waddr;
	logic [BW-1:0]                  rem_wdata;
	logic [ID_W-1:0]                rem_raddr;
	logic [BW-1:0]                  rem_rdata;
	logic                           fifo_we;
	logic [ID_W-1:0]                fifo_waddr;
	logic [ID_W-1:0]                fifo_wdata;
	logic [ID_W-1:0]                fifo_raddr;
	logic [ID_W-1:0]                fifo_rdata;

	rrsf_pkg::scan_ctl_t            scan_ctl;
	rrsf_pkg::scan_res_t            scan_res;
	logic [ID_W-1:0]                best_id;
	logic [BW-1:0]                  best_rem;
	logic [ID_W-1:0]                any_id;
	logic [BW-1:0]                  any_rem;

	// Handshake and load decode
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign is_load  = (s_tuser == rrsf_pkg::KIND_LOAD);
	assign full     = (loaded_q == MAX_CNT);
	assign do_load  = in_acc && is_load && !full;
	assign out_free = !m_tvalid_q || m_tready;

	// FIFO tail and head arithmetic, sum stays below twice the depth
	assign tail_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(fifo_cnt_q);
	assign tail_wrap = (tail_sum >= MAX_WIDE) ? tail_sum - MAX_WIDE : tail_sum;
	assign tail_id   = ID_W'(tail_wrap);
	assign head_inc  = (head_q == LAST_ID) ? '0 : head_q + 1'b1;

	// Round-robin candidate from the FIFO read
	assign cand      = fifo_rdata;
	assign cand_live = live_q[cand];

	// Shortest-first choice; fall back to the only live process left
	assign pick_vld = scan_res.best_vld || scan_res.any_vld;
	assign pick_id  = scan_res.best_vld ? best_id : any_id;
	assign pick_rem = scan_res.best_vld ? best_rem : any_rem;

	// Run one slice, saturating at zero
	assign run_id  = (state_q == S_RUN) ? run_id_q : pick_id;
	assign run_rem = (state_q == S_RUN) ? rem_rdata : pick_rem;
	assign new_rem = (run_rem > slice_q) ? run_rem - slice_q : '0;
	assign run_fin = (new_rem == '0);
	assign do_run  = (state_q == S_RUN) || (state_q == S_SF_PICK && pick_vld);

	// Remaining-time RAM ports
	assign rem_we    = do_load || do_run;
	assign rem_waddr = (state_q == S_IDLE) ? ID_W'(loaded_q) : run_id;
	assign rem_wdata = (state_q == S_IDLE) ? s_tdata[BW-1:0] : new_rem;
	assign rem_raddr = (state_q == S_RR_RD) ? cand : scan_idx_q;

	// Ready FIFO RAM ports
	assign fifo_we    = do_load || (do_run && !run_fin && policy_q == rrsf_pkg::POLICY_RR);
	assign fifo_waddr = tail_id;
	assign fifo_wdata = (state_q == S_IDLE) ? ID_W'(loaded_q) : run_id;
	assign fifo_raddr = (state_q == S_RR_RD) ? head_inc : head_q;

	rrsf_ram #(
		.WIDTH (BW),
		.DEPTH (MAX_PROCESSES)
	) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (rem_raddr),
		.rdata (rem_rdata)
	);

	rrsf_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_PROCESSES)
	) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (fifo_wdata),
		.raddr (fifo_raddr),
		.rdata (fifo_rdata)
	);

	// Scan samples are the RAM address registered, in step with the registered read
	assign scan_ctl.clr  = in_acc;
	assign scan_ctl.vld  = smp_vld_s1;
	assign scan_ctl.live = live_q[smp_idx_s1];
	assign scan_ctl.skip = last_vld_q && (smp_idx_s1 == last_id_q);

	rrsf_scan #(
		.MAX_PROCESSES (MAX_PROCESSES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (smp_idx_s1),
		.rem      (rem_rdata),
		.res      (scan_res),
		.best_id  (best_id),
		.best_rem (best_rem),
		.any_id   (any_id),
		.any_rem  (any_rem)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= rrsf_pkg::POLICY_RR;
			slice_q  <= rrsf_pkg::SLICE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rrsf_pkg::REG_POLICY: policy_q <= cfg_data[0];
				rrsf_pkg::REG_SLICE:  slice_q  <= cfg_data[rrsf_pkg::SLICE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			live_q     <= '0;
			head_q     <= '0;
			fifo_cnt_q <= '0;
			loaded_q   <= '0;
			last_id_q  <= '0;
			last_vld_q <= 1'b0;
			smp_vld_s1 <= 1'b0;
		end else begin
			smp_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (is_load) begin
							if (!full) begin
								live_q[loaded_q[ID_W-1:0]] <= 1'b1;
								fifo_cnt_q <= fifo_cnt_q + 1'b1;
								loaded_q   <= loaded_q + 1'b1;
							end
							state_q <= S_DONE;
						end else if (policy_q == rrsf_pkg::POLICY_RR) begin
							state_q <= (fifo_cnt_q == '0) ? S_DONE : S_RR_RD;
						end else begin
							state_q <= S_SF_SCAN;
						end
					end
				end
				S_RR_RD: begin
					// Pop the head; dead entries are dropped without spending the tick
					head_q     <= head_inc;
					fifo_cnt_q <= fifo_cnt_q - 1'b1;
					if (cand_live) begin
						state_q <= S_RUN;
					end else if (fifo_cnt_q == CNT_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_SF_SCAN: begin
					smp_vld_s1 <= 1'b1;
					if (scan_idx_q == LAST_ID) begin
						state_q <= S_SF_DRAIN;
					end
				end
				S_SF_DRAIN: begin
					state_q <= S_SF_PICK;
				end
				S_RUN, S_SF_PICK: begin
					if (do_run) begin
						last_id_q  <= run_id;
						last_vld_q <= 1'b1;
						if (run_fin) begin
							live_q[run_id] <= 1'b0;
						end else if (policy_q == rrsf_pkg::POLICY_RR) begin
							fifo_cnt_q <= fifo_cnt_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: run id, scan address, pending result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			scan_idx_q <= '0;
			res_ran_q  <= 1'b0;
			res_fin_q  <= 1'b0;
			res_rej_q  <= is_load && full;
			res_id_q   <= (is_load && !full) ? ID_W'(loaded_q) : '0;
		end
		if (state_q == S_RR_RD) begin
			run_id_q <= cand;
		end
		if (state_q == S_SF_SCAN) begin
			smp_idx_s1 <= scan_idx_q;
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (do_run) begin
			res_ran_q <= 1'b1;
			res_id_q  <= run_id;
			res_fin_q <= run_fin;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_tuser_q <= res_ran_q;
			m_tdata_q <= {res_rej_q, res_fin_q, rrsf_pkg::PID_W'(res_id_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// The FIFO never holds more entries than processes loaded
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= loaded_q)
		else $error("ready FIFO count exceeds loaded count");

	// The table never grows past its size
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= MAX_CNT)
		else $error("loaded count exceeds table size");

	// Only loaded slots can be live
	a_live_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q >> loaded_q) == '0)
		else $error("live bit set on an unloaded slot");

	// A running slice always lands on a live process
	a_run_live: assert property (@(posedge clk) disable iff (!arst_n)
		do_run |-> live_q[run_id])
		else $error("slice run on a dead process");

endmodule

// File: design/rrsf_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module rrsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/rrsf_scan.sv
// Shortest-remaining-time scan unit: tracks the best and the first live slot.
module rrsf_scan #(
	parameter int MAX_PROCESSES = rrsf_pkg::MAX_PROCESSES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rrsf_pkg::scan_ctl_t              ctl,
	input  logic [$clog2(MAX_PROCESSES)-1:0] idx,
	input  logic [rrsf_pkg::BURST_W-1:0]     rem,
	output rrsf_pkg::scan_res_t              res,
	output logic [$clog2(MAX_PROCESSES)-1:0] best_id,
	output logic [rrsf_pkg::BURST_W-1:0]     best_rem,
	output logic [$clog2(MAX_PROCESSES)-1:0] any_id,
	output logic [rrsf_pkg::BURST_W-1:0]     any_rem
);

	localparam int ID_W = $clog2(MAX_PROCESSES);

	logic                      best_vld_q;
	logic                      any_vld_q;
	logic [ID_W-1:0]           best_id_q;
	logic [rrsf_pkg::BURST_W-1:0] best_rem_q;
	logic [ID_W-1:0]           any_id_q;
	logic [rrsf_pkg::BURST_W-1:0] any_rem_q;
	logic                      take_best;
	logic                      take_any;

	// Strict less-than keeps the lower id on ties (slots arrive in id order)
	assign take_best = ctl.vld && ctl.live && !ctl.skip && (!best_vld_q || rem < best_rem_q);
	assign take_any  = ctl.vld && ctl.live && !any_vld_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
			any_vld_q  <= 1'b0;
		end else if (ctl.clr) begin
			best_vld_q <= 1'b0;
			any_vld_q  <= 1'b0;
		end else begin
			if (take_best) best_vld_q <= 1'b1;
			if (take_any)  any_vld_q  <= 1'b1;
		end
	end

	// Candidate payload
	always_ff @(posedge clk) begin
		if (take_best) begin
			best_id_q  <= idx;
			best_rem_q <= rem;
		end
		if (take_any) begin
			any_id_q  <= idx;
			any_rem_q <= rem;
		end
	end

	assign res.best_vld = best_vld_q;
	assign res.any_vld  = any_vld_q;
	assign best_id      = best_id_q;
	assign best_rem     = best_rem_q;
	assign any_id       = any_id_q;
	assign any_rem      = any_rem_q;

endmodule
